// ===== rtl/mtd_pkg.sv =====
`timescale 1ns / 1ps
package mtd_pkg;

  localparam int QUEUE_DEPTH      = 32;
  localparam int NUM_LEVELS       = 3;
  localparam int NUM_EVENTS       = 6;
  localparam int TIMERS_PER_GROUP = 10;
  localparam int G0_TIMERS        = (TIMERS_PER_GROUP < 5) ? TIMERS_PER_GROUP : 5;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int QSTORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
  localparam int QADDR_W   = $clog2(QSTORE_DEPTH);
  localparam int TMR_DEPTH = 4 * TIMERS_PER_GROUP;
  localparam int TADDR_W   = $clog2(TMR_DEPTH);
  localparam int TIDX_W    = (TIMERS_PER_GROUP > 1) ? $clog2(TIMERS_PER_GROUP) : 1;
  localparam int EV_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int NUM_FIXED = 15;
  localparam int FIX_W     = 4;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_POST  = 3'd1,
    KIND_RAISE = 3'd2,
    KIND_ARM   = 3'd3,
    KIND_POLL  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ACT_ACK   = 2'd0,
    ACT_TASK  = 2'd1,
    ACT_EVENT = 2'd2,
    ACT_TIMER = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_DIV_FAST = 2'd0,
    REG_DIV_MID  = 2'd1,
    REG_DIV_SLOW = 2'd2
  } reg_e;

  // Rate groups: base tick, 10 ms, 100 ms, 1000 ms
  typedef enum logic [1:0] {
    RATE_TICK = 2'd0,
    RATE_FAST = 2'd1,
    RATE_MID  = 2'd2,
    RATE_SLOW = 2'd3
  } rate_e;

  typedef struct packed {
    logic [5:0]       id;
    logic [LVL_W-1:0] q;
    rate_e            rate;
  } fixed_t;

  typedef struct packed {
    action_e    action;
    logic [5:0] id;
    logic [1:0] grp;
  } res_t;

  typedef struct packed {
    logic              cap;
    logic              pre;
    logic              enq_fix;
    logic              enq_post;
    logic              ev_set;
    logic              tmr_arm;
    logic              tmr_rd;
    logic              tmr_wr;
    logic              ev_emit;
    logic              q_rd;
    logic              q_pop;
    logic              finish;
    logic [FIX_W-1:0]  fix_idx;
    rate_e             grp;
    logic [TIDX_W-1:0] idx;
    logic [EV_W-1:0]   ev_idx;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] fired;
    logic       ev_pend;
    logic       q_any;
    logic       tmr_hit;
    logic       emit_ok;
    logic       out_free;
  } sts_t;

  function automatic logic [LVL_W-1:0] lvl_q(int lvl);
    int l;
    l = (lvl > NUM_LEVELS) ? NUM_LEVELS : lvl;
    return LVL_W'(l - 1);
  endfunction

  function automatic fixed_t mk_fixed(logic [5:0] id, int lvl, rate_e rate);
    fixed_t r;
    r.id   = id;
    r.q    = lvl_q(lvl);
    r.rate = rate;
    return r;
  endfunction

  // Fixed enqueues in the order a tick performs them
  function automatic fixed_t fixed_task(logic [FIX_W-1:0] n);
    fixed_t r;
    case (n)
      4'd0:    r = mk_fixed(6'h1C, 1, RATE_TICK);
      4'd1:    r = mk_fixed(6'h1D, 1, RATE_FAST);
      4'd2:    r = mk_fixed(6'h00, 1, RATE_FAST);
      4'd3:    r = mk_fixed(6'h0C, 1, RATE_FAST);
      4'd4:    r = mk_fixed(6'h0D, 1, RATE_FAST);
      4'd5:    r = mk_fixed(6'h0E, 1, RATE_FAST);
      4'd6:    r = mk_fixed(6'h21, 2, RATE_FAST);
      4'd7:    r = mk_fixed(6'h01, 1, RATE_MID);
      4'd8:    r = mk_fixed(6'h1E, 1, RATE_MID);
      4'd9:    r = mk_fixed(6'h07, 3, RATE_MID);
      4'd10:   r = mk_fixed(6'h10, 2, RATE_MID);
      4'd11:   r = mk_fixed(6'h11, 2, RATE_MID);
      4'd12:   r = mk_fixed(6'h0A, 1, RATE_SLOW);
      4'd13:   r = mk_fixed(6'h02, 1, RATE_SLOW);
      4'd14:   r = mk_fixed(6'h09, 2, RATE_SLOW);
      default: r = mk_fixed(6'h1C, 1, RATE_TICK);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mtd_if.sv =====
`timescale 1ns / 1ps
interface mtd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  task_id;
  logic [1:0]  queue_level;
  logic [5:0]  event_bits;
  logic [1:0]  timer_group;
  logic [3:0]  timer_index;
  logic [15:0] timer_count;

  modport source (output valid, kind, task_id, queue_level, event_bits, timer_group,
                  timer_index, timer_count, input ready);
  modport sink (input valid, kind, task_id, queue_level, event_bits, timer_group,
                timer_index, timer_count, output ready);
endinterface

interface mtd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] call_id;
  logic [1:0] call_group;
  logic       overflow;
  logic       last;

  modport source (output valid, action, call_id, call_group, overflow, last, input ready);
  modport sink (input valid, action, call_id, call_group, overflow, last, output ready);
endinterface

// ===== rtl/multirate_priority_task_dispatcher.sv =====
`timescale 1ns / 1ps
// Task dispatcher with three priority ring queues of 32 task ids, a 5 ms tick
// that drives 10/100/1000 ms prescalers, fixed-rate task enqueues, one-shot
// timers in four rate groups and six pending event bits. One request is taken
// at a time; each produces one or more results, the final one flagged with
// last, and overflow shows the sticky queue overflow flag as it stands once
// the request is done. Post, raise and arm go straight to the final result;
// a poll checks each event bit in turn and then reads the queue. A tick
// runs the prescalers, the fixed enqueue list and then the timers of each
// rate group that fires, one read-modify-write per timer on the timer RAM
// (the 5 timers of the base group are walked on every tick), skipping the
// groups that do not fire, and ends with the final result; a stalled result
// port adds its stall. The queue store and timer counts live in RAMs; timer
// entries carry valid bits so no clearing pass follows reset.
module multirate_priority_task_dispatcher import mtd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i,
  mtd_req_if.sink      req_i,
  mtd_res_if.source    res_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks one request through its steps
  mtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // queues, timers, prescalers, events and the result register
  mtd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (req_i.kind),
    .task_id_i     (req_i.task_id),
    .queue_level_i (req_i.queue_level),
    .event_bits_i  (req_i.event_bits),
    .timer_group_i (req_i.timer_group),
    .timer_index_i (req_i.timer_index),
    .timer_count_i (req_i.timer_count),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .action_o      (res_o.action),
    .call_id_o     (res_o.call_id),
    .call_group_o  (res_o.call_group),
    .overflow_o    (res_o.overflow),
    .last_o        (res_o.last)
  );

endmodule

// ===== rtl/mtd_ram.sv =====
`timescale 1ns / 1ps
module mtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mtd_ctrl.sv =====
`timescale 1ns / 1ps
module mtd_ctrl import mtd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_PRE, ST_ENQ, ST_TRD, ST_TWR, ST_EVT, ST_QRD, ST_QPOP, ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [FIX_W-1:0]  fix_q, fix_d;
  rate_e             grp_q, grp_d;
  logic [TIDX_W-1:0] idx_q, idx_d;
  logic [EV_W-1:0]   evi_q, evi_d;
  logic              grp_active;
  logic [TIDX_W-1:0] grp_last;

  always_comb begin
    unique case (grp_q)
      RATE_TICK: grp_active = 1'b1;
      RATE_FAST: grp_active = sts_i.fired[0];
      RATE_MID:  grp_active = sts_i.fired[1];
      RATE_SLOW: grp_active = sts_i.fired[2];
      default:   grp_active = 1'b0;
    endcase
    grp_last = (grp_q == RATE_TICK) ? TIDX_W'(G0_TIMERS - 1) : TIDX_W'(TIMERS_PER_GROUP - 1);
  end

  always_comb begin
    state_d        = state_q;
    fix_d          = fix_q;
    grp_d          = grp_q;
    idx_d          = idx_q;
    evi_d          = evi_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.fix_idx  = fix_q;
    cmd_o.grp      = grp_q;
    cmd_o.idx      = idx_q;
    cmd_o.ev_idx   = evi_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
        if (in_valid_i) state_d = ST_DISP;
      end
      ST_DISP: begin
        state_d = ST_FIN;
        unique case (sts_i.kind)
          KIND_TICK:  state_d = ST_PRE;
          KIND_POST:  cmd_o.enq_post = 1'b1;
          KIND_RAISE: cmd_o.ev_set = 1'b1;
          KIND_ARM:   cmd_o.tmr_arm = 1'b1;
          KIND_POLL: begin
            evi_d   = '0;
            state_d = ST_EVT;
          end
          default: ;
        endcase
      end
      ST_PRE: begin
        cmd_o.pre = 1'b1;
        fix_d     = '0;
        state_d   = ST_ENQ;
      end
      ST_ENQ: begin
        cmd_o.enq_fix = 1'b1;
        if (fix_q == FIX_W'(NUM_FIXED - 1)) begin
          grp_d   = RATE_TICK;
          idx_d   = '0;
          state_d = ST_TRD;
        end else begin
          fix_d = fix_q + 1'b1;
        end
      end
      ST_TRD: begin
        if (grp_active) begin
          cmd_o.tmr_rd = 1'b1;
          state_d      = ST_TWR;
        end else if (grp_q == RATE_SLOW) begin
          state_d = ST_FIN;
        end else begin
          grp_d = rate_e'(grp_q + 2'd1);
          idx_d = '0;
        end
      end
      ST_TWR: begin
        // hold while an expiring timer has nowhere to go
        if (!(sts_i.tmr_hit && !sts_i.emit_ok)) begin
          cmd_o.tmr_wr = 1'b1;
          if (idx_q == grp_last) begin
            idx_d = '0;
            if (grp_q == RATE_SLOW) begin
              state_d = ST_FIN;
            end else begin
              grp_d   = rate_e'(grp_q + 2'd1);
              state_d = ST_TRD;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_TRD;
          end
        end
      end
      ST_EVT: begin
        if (!(sts_i.ev_pend && !sts_i.emit_ok)) begin
          cmd_o.ev_emit = sts_i.ev_pend;
          if (evi_q == EV_W'(NUM_EVENTS - 1)) state_d = ST_QRD;
          else evi_d = evi_q + 1'b1;
        end
      end
      ST_QRD: begin
        if (sts_i.q_any) begin
          cmd_o.q_rd = 1'b1;
          state_d    = ST_QPOP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_QPOP: begin
        if (sts_i.emit_ok) begin
          cmd_o.q_pop = 1'b1;
          state_d     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fix_q   <= '0;
      grp_q   <= RATE_TICK;
      idx_q   <= '0;
      evi_q   <= '0;
    end else begin
      state_q <= state_d;
      fix_q   <= fix_d;
      grp_q   <= grp_d;
      idx_q   <= idx_d;
      evi_q   <= evi_d;
    end
  end

endmodule

// ===== rtl/mtd_datapath.sv =====
`timescale 1ns / 1ps
module mtd_datapath import mtd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  task_id_i,
  input  logic [1:0]  queue_level_i,
  input  logic [5:0]  event_bits_i,
  input  logic [1:0]  timer_group_i,
  input  logic [3:0]  timer_index_i,
  input  logic [15:0] timer_count_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  action_o,
  output logic [5:0]  call_id_o,
  output logic [1:0]  call_group_o,
  output logic        overflow_o,
  output logic        last_o
);

  // captured request
  logic [2:0]  kind_q;
  logic [5:0]  task_id_q;
  logic [1:0]  level_q;
  logic [5:0]  ebits_q;
  logic [1:0]  tgroup_q;
  logic [3:0]  tindex_q;
  logic [15:0] tcount_q;

  logic [7:0]            div_q [3];
  logic [7:0]            pre_q [3];
  logic [7:0]            pre_dec [3];
  logic [2:0]            fired_q;
  logic [NUM_EVENTS-1:0] pend_q;
  logic                  ovf_q;
  logic [PTR_W-1:0]      rptr_q [NUM_LEVELS];
  logic [PTR_W-1:0]      wptr_q [NUM_LEVELS];
  logic [LVL_W-1:0]      qsel_q;
  logic [TMR_DEPTH-1:0]  tvalid_q;
  logic                  tvrd_q;

  logic              hold_v_q;
  res_t              hold_q;
  logic              out_v_q;
  res_t              out_q;
  logic              out_ovf_q;
  logic              out_last_q;

  // enqueue path
  fixed_t            fx;
  logic              fix_on, post_ok, enq_en, coll;
  logic [LVL_W-1:0]  enq_q;
  logic [5:0]        enq_id;
  logic [PTR_W-1:0]  wp_cur, wp1, wp_new;
  logic [QADDR_W-1:0] q_waddr, q_raddr;
  logic [5:0]        q_rdata;
  logic [LVL_W-1:0]  q_hi;
  logic              q_any;

  // timer path
  logic              arm_ok, t_we, hit;
  logic [TADDR_W-1:0] t_waddr, t_raddr;
  logic [15:0]       t_wdata, t_rdata, tval;

  logic              emit_v, out_free, emit_ok;
  res_t              emit_r;

  function automatic logic [PTR_W-1:0] nxt(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TADDR_W-1:0] taddr(logic [1:0] g, logic [3:0] i);
    return TADDR_W'(g) * TADDR_W'(TIMERS_PER_GROUP) + TADDR_W'(i);
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) pre_dec[k] = pre_q[k] - 8'd1;

    fx = fixed_task(cmd_i.fix_idx);
    unique case (fx.rate)
      RATE_TICK: fix_on = 1'b1;
      RATE_FAST: fix_on = fired_q[0];
      RATE_MID:  fix_on = fired_q[1];
      RATE_SLOW: fix_on = fired_q[2];
      default:   fix_on = 1'b0;
    endcase
    post_ok = (level_q != 2'd0) && (int'(level_q) <= NUM_LEVELS);
    enq_en  = (cmd_i.enq_fix && fix_on) || (cmd_i.enq_post && post_ok);
    enq_q   = cmd_i.enq_fix ? fx.q : LVL_W'(level_q - 2'd1);
    enq_id  = cmd_i.enq_fix ? fx.id : task_id_q;
    wp_cur  = wptr_q[enq_q];
    wp1     = nxt(wp_cur);
    coll    = (wp1 == rptr_q[enq_q]);
    wp_new  = coll ? nxt(wp1) : wp1;
    q_waddr = QADDR_W'(enq_q) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(wp_cur);

    // lowest-numbered non-empty queue wins
    q_hi  = '0;
    q_any = 1'b0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (wptr_q[l] != rptr_q[l]) begin
        q_hi  = LVL_W'(l);
        q_any = 1'b1;
      end
    end
    q_raddr = QADDR_W'(q_hi) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(rptr_q[q_hi]);

    arm_ok  = (tgroup_q == 2'd0) ? (int'(tindex_q) < G0_TIMERS)
                                 : (int'(tindex_q) < TIMERS_PER_GROUP);
    tval    = tvrd_q ? t_rdata : 16'd0;
    hit     = (tval == 16'd1);
    t_raddr = taddr(cmd_i.grp, 4'(cmd_i.idx));
    t_waddr = cmd_i.tmr_arm ? taddr(tgroup_q, tindex_q) : t_raddr;
    t_wdata = cmd_i.tmr_arm ? tcount_q : tval - 16'd1;
    t_we    = (cmd_i.tmr_arm && arm_ok) || (cmd_i.tmr_wr && tval != 16'd0);

    emit_v = 1'b0;
    emit_r = '{action: ACT_ACK, id: 6'd0, grp: 2'd0};
    if (cmd_i.tmr_wr && hit) begin
      emit_v = 1'b1;
      emit_r = '{action: ACT_TIMER, id: 6'(cmd_i.idx), grp: 2'(cmd_i.grp)};
    end else if (cmd_i.ev_emit) begin
      emit_v = 1'b1;
      emit_r = '{action: ACT_EVENT, id: 6'(cmd_i.ev_idx), grp: 2'd0};
    end else if (cmd_i.q_pop) begin
      emit_v = 1'b1;
      emit_r = '{action: ACT_TASK, id: q_rdata, grp: 2'd0};
    end

    out_free = !out_v_q || out_ready_i;
    emit_ok  = !hold_v_q || out_free;
  end

  mtd_ram #(.WIDTH(6), .DEPTH(QSTORE_DEPTH)) u_qram (
    .clk_i   (clk_i),
    .we_i    (enq_en),
    .waddr_i (q_waddr),
    .wdata_i (enq_id),
    .re_i    (cmd_i.q_rd),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  mtd_ram #(.WIDTH(16), .DEPTH(TMR_DEPTH)) u_tram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (cmd_i.tmr_rd),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // request capture and result payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q    <= kind_i;
      task_id_q <= task_id_i;
      level_q   <= queue_level_i;
      ebits_q   <= event_bits_i;
      tgroup_q  <= timer_group_i;
      tindex_q  <= timer_index_i;
      tcount_q  <= timer_count_i;
    end
    if (cmd_i.q_rd) qsel_q <= q_hi;
    if (cmd_i.finish) begin
      out_q      <= hold_v_q ? hold_q : '{action: ACT_ACK, id: 6'd0, grp: 2'd0};
      out_ovf_q  <= ovf_q;
      out_last_q <= 1'b1;
    end else if (emit_v) begin
      hold_q <= emit_r;
      if (hold_v_q) begin
        out_q      <= hold_q;
        out_ovf_q  <= ovf_q;
        out_last_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= '{8'd2, 8'd20, 8'd200};
      pre_q    <= '{8'd2, 8'd20, 8'd200};
      fired_q  <= '0;
      pend_q   <= '0;
      ovf_q    <= 1'b0;
      rptr_q   <= '{default: '0};
      wptr_q   <= '{default: '0};
      tvalid_q <= '0;
      tvrd_q   <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DIV_FAST: div_q[0] <= cfg_wdata_i;
          REG_DIV_MID:  div_q[1] <= cfg_wdata_i;
          REG_DIV_SLOW: div_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.pre) begin
        for (int k = 0; k < 3; k++) begin
          fired_q[k] <= (pre_dec[k] == 8'd0);
          pre_q[k]   <= (pre_dec[k] == 8'd0) ? div_q[k] : pre_dec[k];
        end
        if (pre_dec[1] == 8'd0) pend_q[0] <= 1'b1;
      end
      if (cmd_i.ev_set) pend_q <= pend_q | NUM_EVENTS'(ebits_q);
      if (cmd_i.ev_emit) pend_q[cmd_i.ev_idx] <= 1'b0;
      if (enq_en) begin
        wptr_q[enq_q] <= wp_new;
        if (coll) ovf_q <= 1'b1;
      end
      if (cmd_i.q_pop) rptr_q[qsel_q] <= nxt(rptr_q[qsel_q]);
      if (t_we) tvalid_q[t_waddr] <= 1'b1;
      if (cmd_i.tmr_rd) tvrd_q <= tvalid_q[t_raddr];

      if (out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.finish) begin
        out_v_q  <= 1'b1;
        hold_v_q <= 1'b0;
      end else if (emit_v) begin
        hold_v_q <= 1'b1;
        if (hold_v_q) out_v_q <= 1'b1;
      end
    end
  end

  assign sts_o.kind     = kind_e'(kind_q);
  assign sts_o.fired    = fired_q;
  assign sts_o.ev_pend  = pend_q[cmd_i.ev_idx];
  assign sts_o.q_any    = q_any;
  assign sts_o.tmr_hit  = hit;
  assign sts_o.emit_ok  = emit_ok;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_v_q;
  assign action_o     = out_q.action;
  assign call_id_o    = out_q.id;
  assign call_group_o = out_q.grp;
  assign overflow_o   = out_ovf_q;
  assign last_o       = out_last_q;

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (out_v_q && out_last_q))
    else $error("closing result not marked last");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag dropped");

  a_hold_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_v && hold_v_q && !cmd_i.finish) |=> (out_v_q && !out_last_q && hold_v_q))
    else $error("held result not pushed out");

endmodule

// ===== test/multirate_priority_task_dispatcher_test.sv =====
`timescale 1ns / 1ps
// Checks the dispatcher against a behavioral predictor of queues, prescalers,
// timers and events. Requests go in through the request channel with random
// gaps, results are drained with random stalls and compared in order.
module multirate_priority_task_dispatcher_test;
  import mtd_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;

  mtd_req_if req_if();
  mtd_res_if res_if();

  multirate_priority_task_dispatcher u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .res_o      (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    action_e    action;
    logic [5:0] call_id;
    logic [1:0] call_group;
    logic       overflow;
    logic       last;
  } dispatch_t;

  // Predicted dispatcher state
  logic [5:0]  queue_mem [NUM_LEVELS][QUEUE_DEPTH];
  logic [4:0]  rd_ptr [NUM_LEVELS];
  logic [4:0]  wr_ptr [NUM_LEVELS];
  logic        ovf_flag;
  logic [5:0]  events_pending;
  logic [7:0]  prescaler [3];
  logic [7:0]  divider [3];
  logic [15:0] timer_cnt [4][TIMERS_PER_GROUP];

  dispatch_t expected_calls[$];
  dispatch_t step_calls[$];
  int        errors = 0;
  int        idle_pct = 38;   // chance of a gap on either side
  bit        hold_results = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void add_call(action_e act, logic [5:0] id, logic [1:0] grp);
    dispatch_t d;
    d.action = act;
    d.call_id = id;
    d.call_group = grp;
    d.overflow = 1'b0;
    d.last = 1'b0;
    step_calls.push_back(d);
  endfunction

  function automatic void push_task(logic [5:0] id, int lvl);
    int q;
    q = ((lvl > NUM_LEVELS) ? NUM_LEVELS : lvl) - 1;
    queue_mem[q][wr_ptr[q]] = id;
    wr_ptr[q]++;
    if (wr_ptr[q] == rd_ptr[q]) begin
      ovf_flag = 1'b1;
      wr_ptr[q]++;
    end
  endfunction

  function automatic void count_down(int grp, int n);
    for (int i = 0; i < n; i++) begin
      if (timer_cnt[grp][i] != 0) begin
        timer_cnt[grp][i]--;
        if (timer_cnt[grp][i] == 0) add_call(ACT_TIMER, 6'(i), 2'(grp));
      end
    end
  endfunction

  function automatic bit rate_fires(int k);
    prescaler[k]--;
    if (prescaler[k] == 0) begin
      prescaler[k] = divider[k];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void reset_model();
    for (int q = 0; q < NUM_LEVELS; q++) begin
      rd_ptr[q] = '0;
      wr_ptr[q] = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) queue_mem[q][i] = '0;
    end
    for (int g = 0; g < 4; g++)
      for (int i = 0; i < TIMERS_PER_GROUP; i++) timer_cnt[g][i] = '0;
    ovf_flag = 1'b0;
    events_pending = '0;
    divider[0] = 8'd2;   divider[1] = 8'd20;   divider[2] = 8'd200;
    prescaler[0] = 8'd2; prescaler[1] = 8'd20; prescaler[2] = 8'd200;
  endfunction

  // Work out the results of one request and append them to the expectations
  function automatic void predict_dispatch(logic [2:0] kind, logic [5:0] tid,
                                           logic [1:0] lvl, logic [5:0] ebits,
                                           logic [1:0] grp, logic [3:0] idx,
                                           logic [15:0] cnt);
    int lim;
    dispatch_t d;
    step_calls = {};
    case (kind)
      KIND_TICK: begin
        push_task(6'h1C, 1);
        count_down(RATE_TICK, G0_TIMERS);
        if (rate_fires(0)) begin
          push_task(6'h1D, 1); push_task(6'h00, 1); push_task(6'h0C, 1);
          push_task(6'h0D, 1); push_task(6'h0E, 1); push_task(6'h21, 2);
          count_down(RATE_FAST, TIMERS_PER_GROUP);
        end
        if (rate_fires(1)) begin
          events_pending[0] = 1'b1;
          push_task(6'h01, 1); push_task(6'h1E, 1); push_task(6'h07, 3);
          push_task(6'h10, 2); push_task(6'h11, 2);
          count_down(RATE_MID, TIMERS_PER_GROUP);
        end
        if (rate_fires(2)) begin
          push_task(6'h0A, 1); push_task(6'h02, 1); push_task(6'h09, 2);
          count_down(RATE_SLOW, TIMERS_PER_GROUP);
        end
      end
      KIND_POST: if (lvl != 0 && lvl <= NUM_LEVELS) push_task(tid, lvl);
      KIND_RAISE: events_pending |= ebits;
      KIND_ARM: begin
        lim = (grp == RATE_TICK) ? G0_TIMERS : TIMERS_PER_GROUP;
        if (idx < lim) timer_cnt[grp][idx] = cnt;
      end
      KIND_POLL: begin
        for (int e = 0; e < NUM_EVENTS; e++)
          if (events_pending[e]) begin
            events_pending[e] = 1'b0;
            add_call(ACT_EVENT, 6'(e), 2'd0);
          end
        for (int q = 0; q < NUM_LEVELS; q++)
          if (wr_ptr[q] != rd_ptr[q]) begin
            add_call(ACT_TASK, queue_mem[q][rd_ptr[q]], 2'd0);
            rd_ptr[q]++;
            break;
          end
      end
      default: ;
    endcase
    if (step_calls.size() == 0) add_call(ACT_ACK, 6'd0, 2'd0);
    foreach (step_calls[k]) begin
      d = step_calls[k];
      d.overflow = ovf_flag;
      d.last = (k == step_calls.size() - 1);
      expected_calls.push_back(d);
    end
  endfunction

  // Send one request; predict at acceptance. The block never takes a request
  // on the cycle after an acceptance, so start at a falling edge after the one
  // at which the previous request dropped valid.
  task automatic send_request(input logic [2:0] kind, input logic [5:0] tid,
                              input logic [1:0] lvl, input logic [5:0] ebits,
                              input logic [1:0] grp, input logic [3:0] idx,
                              input logic [15:0] cnt);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.kind <= kind;
    req_if.task_id <= tid;
    req_if.queue_level <= lvl;
    req_if.event_bits <= ebits;
    req_if.timer_group <= grp;
    req_if.timer_index <= idx;
    req_if.timer_count <= cnt;
    do @(posedge clk_i); while (!req_if.ready);
    predict_dispatch(kind, tid, lvl, ebits, grp, idx, cnt);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  task automatic send_random(input int kind_hint);
    logic [2:0] k;
    k = (kind_hint >= 0) ? 3'(kind_hint) : 3'($urandom_range(7));
    send_request(k, 6'($urandom), 2'($urandom), 6'($urandom), 2'($urandom),
                 ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(9)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
  endtask

  // Hold until every result is in, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while (expected_calls.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_divider(input reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    divider[idx] = val;
  endtask

  // Result checker: sample at the rising edge
  always @(posedge clk_i) begin
    dispatch_t got, exp_d;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.action = action_e'(res_if.action);
      got.call_id = res_if.call_id;
      got.call_group = res_if.call_group;
      got.overflow = res_if.overflow;
      got.last = res_if.last;
      if (expected_calls.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_d = expected_calls.pop_front();
        if (got.action !== exp_d.action)
          report_mismatch($sformatf("action %0d exp %0d", got.action, exp_d.action));
        if (got.call_id !== exp_d.call_id)
          report_mismatch($sformatf("call_id %0d exp %0d", got.call_id, exp_d.call_id));
        if (got.call_group !== exp_d.call_group)
          report_mismatch($sformatf("call_group %0d exp %0d", got.call_group,
                                    exp_d.call_group));
        if (got.overflow !== exp_d.overflow)
          report_mismatch($sformatf("overflow %0b exp %0b", got.overflow, exp_d.overflow));
        if (got.last !== exp_d.last)
          report_mismatch($sformatf("last %0b exp %0b", got.last, exp_d.last));
      end
    end
  end

  // Result ready: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni || hold_results) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic test_directed();
    // idle poll, then extremes of every field
    send_request(KIND_POLL, 0, 0, 0, 0, 0, 0);
    send_request(KIND_POST, 6'h3F, 2'd1, 0, 0, 0, 0);
    send_request(KIND_POST, 6'h00, 2'd3, 0, 0, 0, 0);
    send_request(KIND_POST, 6'h2A, 2'd2, 0, 0, 0, 0);
    send_request(KIND_POST, 6'h15, 2'd0, 0, 0, 0, 0);   // level zero dropped
    send_request(KIND_RAISE, 0, 0, 6'h3F, 0, 0, 0);
    send_request(KIND_ARM, 0, 0, 0, RATE_TICK, 4'd4, 16'd1);
    send_request(KIND_ARM, 0, 0, 0, RATE_TICK, 4'd5, 16'd1); // index out of group
    send_request(KIND_ARM, 0, 0, 0, RATE_FAST, 4'd9, 16'd1);
    send_request(KIND_ARM, 0, 0, 0, RATE_SLOW, 4'd15, 16'hFFFF);
    send_request(KIND_ARM, 0, 0, 0, RATE_MID, 4'd0, 16'hFFFF);
    send_request(KIND_ARM, 0, 0, 0, RATE_MID, 4'd0, 16'd0);  // disarm
    send_request(3'd5, 6'h3F, 2'd3, 6'h3F, 2'd3, 4'hF, 16'hFFFF);
    send_request(3'd7, 0, 0, 0, 0, 0, 0);
    send_request(KIND_TICK, 0, 0, 0, 0, 0, 0);
    send_request(KIND_TICK, 0, 0, 0, 0, 0, 0);
    send_request(KIND_POLL, 0, 0, 0, 0, 0, 0);
    send_request(KIND_POLL, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_overflow_backpressure();
    // Hold results while posts pile up, then wrap level 3 past its depth
    hold_results = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_results = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_request(KIND_POST, 6'(i), 2'd3, 0, 0, 0, 0);
    join
    for (int i = 0; i < 5; i++) send_request(KIND_POLL, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_dividers();
    // Fast rates at the extremes, with timers armed to fire
    write_divider(REG_DIV_FAST, 8'd1);
    write_divider(REG_DIV_MID, 8'd1);
    write_divider(REG_DIV_SLOW, 8'd255);
    for (int g = 0; g < 4; g++)
      for (int i = 0; i < ((g == 0) ? G0_TIMERS : TIMERS_PER_GROUP); i++)
        send_request(KIND_ARM, 0, 0, 0, 2'(g), 4'(i), 16'd2);
    for (int i = 0; i < 6; i++) send_request(KIND_TICK, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_request(KIND_POLL, 0, 0, 0, 0, 0, 0);
    drain();
    write_divider(REG_DIV_FAST, 8'd0);   // period of 256 ticks
    write_divider(REG_DIV_MID, 8'd3);
    write_divider(REG_DIV_SLOW, 8'd2);
    drain();
  endtask

  task automatic test_random();
    // Mostly ticks, polls and arms so timers expire; a stretch with no gaps or stalls near the end
    for (int i = 0; i < 168; i++) begin
      if (i == 110) idle_pct = 0;
      if (i == 150) idle_pct = 38;
      case ($urandom_range(9))
        0, 1, 2: send_random(KIND_TICK);
        3, 4:    send_random(KIND_POLL);
        5, 6:    send_random(KIND_ARM);
        7:       send_random(KIND_POST);
        8:       send_random(KIND_RAISE);
        default: send_random(-1);
      endcase
      if (i == 85) begin
        drain();
        write_divider(REG_DIV_FAST, 8'($urandom_range(1, 4)));
        write_divider(REG_DIV_MID, 8'($urandom_range(2, 6)));
        write_divider(REG_DIV_SLOW, 8'($urandom_range(3, 10)));
      end
    end
    drain();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.kind = '0;
    req_if.task_id = '0;
    req_if.queue_level = '0;
    req_if.event_bits = '0;
    req_if.timer_group = '0;
    req_if.timer_index = '0;
    req_if.timer_count = '0;
    res_if.ready = 1'b0;
    reset_model();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow_backpressure();
    test_dividers();
    test_random();
    if (errors == 0 && expected_calls.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
